### sv/gdd_pkg.sv
// shared types, constants and calendar tables for the gregorian date difference block
package gdd_pkg;

  localparam int unsigned DayW   = 6;
  localparam int unsigned MonthW = 4;
  localparam int unsigned YearW  = 14;
  localparam int unsigned DistW  = 22;
  // day number width: (2^YearW - 2) * 365 plus leap and month terms stays below 2^23
  localparam int unsigned DayNumW = 23;

  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 32;

  // floor(x / 25) as (x * Recip25) >> Recip25Shift, exact for x < 4096
  localparam int unsigned Recip25Shift = 16;
  localparam logic [11:0] Recip25      = 12'd2622;

  localparam logic [DistW-1:0] DistMax = '1;

  typedef enum logic [1:0] {
    ORDER_EQUAL   = 2'b00,
    ORDER_LATER   = 2'b01,
    ORDER_EARLIER = 2'b11
  } gdd_order_e;

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
  } gdd_date_t;

  typedef struct packed {
    logic               valid;
    logic [DayNumW-1:0] day_num;
  } gdd_date_info_t;

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] month);
    logic [DayW-1:0] len;
    case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 6'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 6'd30;
      4'd2:                                       len = 6'd28;
      default:                                    len = 6'd0;
    endcase
    return len;
  endfunction

  // days before the first of the month in a common year
  function automatic logic [8:0] month_start(input logic [MonthW-1:0] month);
    logic [8:0] start;
    case (month)
      4'd1:    start = 9'd0;
      4'd2:    start = 9'd31;
      4'd3:    start = 9'd59;
      4'd4:    start = 9'd90;
      4'd5:    start = 9'd120;
      4'd6:    start = 9'd151;
      4'd7:    start = 9'd181;
      4'd8:    start = 9'd212;
      4'd9:    start = 9'd243;
      4'd10:   start = 9'd273;
      4'd11:   start = 9'd304;
      4'd12:   start = 9'd334;
      default: start = 9'd0;
    endcase
    return start;
  endfunction

endpackage

### sv/gdd_date_unit.sv
// validity check and closed-form day number of one date
module gdd_date_unit (
  input  gdd_pkg::gdd_date_t      date_i,
  output gdd_pkg::gdd_date_info_t info_o
);
  import gdd_pkg::*;

  logic [YearW-1:0]   prev_year;
  logic [11:0]        p_div4;
  logic [23:0]        p_prod;
  logic [7:0]         p_div100;
  logic [5:0]         p_div400;
  logic [11:0]        y_div4;
  logic [23:0]        y_prod;
  logic [7:0]         y_div100;
  logic [12:0]        y_back;
  logic [4:0]         y_rem25;
  logic               leap;
  logic               month_ok;
  logic [DayW-1:0]    len;
  logic [DayNumW-1:0] base;

  assign prev_year = date_i.year - YearW'(1);

  // year/4, year/100 and year/400 of the previous year
  assign p_div4   = prev_year[YearW-1:2];
  assign p_prod   = 24'(p_div4) * 24'(Recip25);
  assign p_div100 = p_prod[23:Recip25Shift];
  assign p_div400 = p_div100[7:2];

  // leap test: year = 4*y_div4, then split y_div4 into 25*y_div100 + y_rem25
  assign y_div4   = date_i.year[YearW-1:2];
  assign y_prod   = 24'(y_div4) * 24'(Recip25);
  assign y_div100 = y_prod[23:Recip25Shift];
  assign y_back   = 13'(y_div100) * 13'd25;
  assign y_rem25  = 5'(13'(y_div4) - y_back);
  assign leap     = (date_i.year[1:0] == 2'b00) &&
                    ((y_rem25 != 5'd0) || (y_div100[1:0] == 2'b00));

  assign month_ok = (date_i.month inside {[4'd1:4'd12]});

  always_comb begin
    len = month_len(date_i.month);
    if (date_i.month == 4'd2 && leap) begin
      len = len + DayW'(1);
    end
  end

  assign info_o.valid = month_ok && (date_i.year != '0) && (date_i.day != '0) &&
                        (date_i.day <= len);

  assign base = DayNumW'(prev_year) * DayNumW'(365) + DayNumW'(p_div4) -
                DayNumW'(p_div100) + DayNumW'(p_div400);

  assign info_o.day_num = base + DayNumW'(month_start(date_i.month)) +
                          DayNumW'((date_i.month > 4'd2) && leap) +
                          DayNumW'(date_i.day);

endmodule

### sv/gdd_result.sv
// ordering of the raw fields and saturated absolute day distance, 0 when either date is invalid
module gdd_result (
  input  gdd_pkg::gdd_date_t      first_i,
  input  gdd_pkg::gdd_date_t      second_i,
  input  gdd_pkg::gdd_date_info_t first_info_i,
  input  gdd_pkg::gdd_date_info_t second_info_i,
  output gdd_pkg::gdd_order_e     order_o,
  output logic [gdd_pkg::DistW-1:0] day_distance_o
);
  import gdd_pkg::*;

  logic [DayNumW-1:0] diff;

  // packed year, month, day compares in field priority order
  always_comb begin
    if (first_i == second_i) begin
      order_o = ORDER_EQUAL;
    end else if (first_i > second_i) begin
      order_o = ORDER_LATER;
    end else begin
      order_o = ORDER_EARLIER;
    end
  end

  assign diff = (first_info_i.day_num > second_info_i.day_num) ?
                (first_info_i.day_num - second_info_i.day_num) :
                (second_info_i.day_num - first_info_i.day_num);

  always_comb begin
    if (!(first_info_i.valid && second_info_i.valid)) begin
      day_distance_o = '0;
    end else if (diff > DayNumW'(DistMax)) begin
      day_distance_o = DistMax;
    end else begin
      day_distance_o = diff[DistW-1:0];
    end
  end

endmodule

### sv/gregorian_date_difference.sv
// top level of the gregorian date difference block
// Takes one pair of dates per word and returns one result word: a validity flag for
// each date, the ordering of the two dates (year, then month, then day, from the raw
// fields) and the absolute number of days between them, 0 when either date is invalid
// and saturated at 22 bits. The datapath is an input register, closed-form day number
// logic for both dates and an output register, so when the output is not stalled a word
// can be accepted every cycle and each result is on the master side from the clock edge
// after the one that accepts its word. The input register holds its word only while
// the output register is full and stalled by master-side backpressure.
module gregorian_date_difference (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // first_day[5:0], first_month[9:6], first_year[23:10],
  // second_day[29:24], second_month[33:30], second_year[47:34]
  input  logic [gdd_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // first_valid[0], second_valid[1], order[3:2], day_distance[25:4], zero fill above
  output logic [gdd_pkg::OutDataW-1:0]  m_axis_tdata
);
  import gdd_pkg::*;

  logic            in_valid_q;
  gdd_date_t       first_q, second_q;
  logic            out_valid_q;
  logic            out_first_valid_q, out_second_valid_q;
  gdd_order_e      out_order_q;
  logic [DistW-1:0] out_dist_q;

  logic            out_ready;
  logic            in_ready;
  gdd_date_info_t  first_info, second_info;
  gdd_order_e      order_d;
  logic [DistW-1:0] dist_d;

  assign out_ready     = !out_valid_q || m_axis_tready;
  assign in_ready      = !in_valid_q || out_ready;
  assign s_axis_tready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && s_axis_tvalid) begin
      first_q.day   <= s_axis_tdata[5:0];
      first_q.month <= s_axis_tdata[9:6];
      first_q.year  <= s_axis_tdata[23:10];
      second_q.day   <= s_axis_tdata[29:24];
      second_q.month <= s_axis_tdata[33:30];
      second_q.year  <= s_axis_tdata[47:34];
    end
  end

  gdd_date_unit u_first_date (
    .date_i (first_q),
    .info_o (first_info)
  );

  gdd_date_unit u_second_date (
    .date_i (second_q),
    .info_o (second_info)
  );

  gdd_result u_result (
    .first_i        (first_q),
    .second_i       (second_q),
    .first_info_i   (first_info),
    .second_info_i  (second_info),
    .order_o        (order_d),
    .day_distance_o (dist_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && in_valid_q) begin
      out_first_valid_q  <= first_info.valid;
      out_second_valid_q <= second_info.valid;
      out_order_q        <= order_d;
      out_dist_q         <= dist_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_dist_q, out_order_q, out_second_valid_q,
                          out_first_valid_q};

endmodule
